FILE: rtl/core/mclbp_pkg.sv
// Package for the multi-channel LED breathing PWM block.
// Holds the breathing table, register indexes and reset values.
// No dependencies.
`default_nettype none

package mclbp_pkg;

  // Index and value widths of the breathing table.
  localparam int unsigned IdxW = 6;
  localparam int unsigned TableSlots = 64;
  localparam int unsigned LevelW = 8;

  // Configuration register indexes (byte address divided by four).
  localparam logic RegPwmPeriod = 1'b0;
  localparam logic RegStepInterval = 1'b1;

  // Register reset values.
  localparam logic [7:0] PwmPeriodRst = 8'd100;
  localparam logic [7:0] StepIntervalRst = 8'd200;

  // Breathing curve; slots past the curve read zero.
  localparam logic [LevelW-1:0] BreathTable [TableSlots] = '{
    8'd0, 8'd2, 8'd2, 8'd2, 8'd4, 8'd4, 8'd4, 8'd4, 8'd6, 8'd8, 8'd8, 8'd12,
    8'd14, 8'd18, 8'd22, 8'd28, 8'd36, 8'd46, 8'd56, 8'd68, 8'd78, 8'd90,
    8'd96, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd96,
    8'd90, 8'd78, 8'd68, 8'd56, 8'd46, 8'd36, 8'd28, 8'd22, 8'd18, 8'd14,
    8'd12, 8'd8, 8'd8, 8'd6, 8'd4, 8'd4, 8'd4, 8'd4, 8'd2, 8'd2, 8'd2, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

endpackage

`default_nettype wire

FILE: rtl/core/multi_channel_led_breathing_pwm.sv
// Top level of the multi-channel LED breathing PWM block.
// Depends on mclbp_pkg for the breathing table and register constants.
//
// Channel  | Direction | Handshake              | Fields
// ---------+-----------+------------------------+----------------------------------
// in       | input     | in_valid_i / in_stall_o | channel_enable_i[15:0]
// out      | output    | out_valid_o / out_stall_i | led_levels_o[15:0], counter_wrapped_o
// config   | input     | APB (psel, penable)    | pwm_period, step_interval
//
// One word is accepted per clock cycle while in_stall_o is low; its result appears
// after the input register and the result register. The channel compares
// against the table all sit between those two registers.
// Reset clears the counters and levels and sets channel i's index to 2*i modulo 64.
// A stalled result holds; one further word waits in the input register.
`default_nettype none

module multi_channel_led_breathing_pwm #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned TABLE_LENGTH = 52
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input word channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] channel_enable_i,
  // Result word channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      led_levels_o,
  output logic             counter_wrapped_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IdxW = mclbp_pkg::IdxW;
  localparam int unsigned LevelW = mclbp_pkg::LevelW;
  localparam int unsigned EnW = (CHANNELS < 16) ? CHANNELS : 16;

  // Configuration registers.
  logic [7:0] pwm_period_q, step_interval_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_period_q    <= mclbp_pkg::PwmPeriodRst;
      step_interval_q <= mclbp_pkg::StepIntervalRst;
    end else if (cfg_wr) begin
      if (paddr[2] == mclbp_pkg::RegPwmPeriod) begin
        pwm_period_q <= pwdata[7:0];
      end else begin
        step_interval_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      mclbp_pkg::RegPwmPeriod:    prdata = {24'd0, pwm_period_q};
      mclbp_pkg::RegStepInterval: prdata = {24'd0, step_interval_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // Handshake: the input register moves on when the result register is free.
  logic        s1_valid_q;
  logic [15:0] s1_enable_q;
  logic        out_free, s1_adv, in_acc;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_enable_q <= channel_enable_i;
    end
  end

  // Shared counters for the word in the input register.
  logic [7:0] pwm_count_q, pwm_count_d, pwm_inc;
  logic [7:0] step_count_q, step_count_d;
  logic       wrap, step_fire;

  assign wrap      = pwm_count_q >= pwm_period_q;
  assign pwm_inc   = pwm_count_q + 8'd1;
  assign step_fire = !wrap && (step_count_q >= step_interval_q);

  always_comb begin
    pwm_count_d  = pwm_count_q;
    step_count_d = step_count_q;
    if (wrap) begin
      pwm_count_d = 8'd0;
    end else begin
      pwm_count_d  = pwm_inc;
      step_count_d = step_fire ? 8'd0 : step_count_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_count_q  <= 8'd0;
      step_count_q <= 8'd0;
    end else if (s1_adv) begin
      pwm_count_q  <= pwm_count_d;
      step_count_q <= step_count_d;
    end
  end

  // Per-channel table index, table lookup and level compare.
  logic [CHANNELS-1:0] level_bits_q, level_new;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    localparam logic [IdxW-1:0] IdxRst = IdxW'((2 * i) % mclbp_pkg::TableSlots);
    logic [IdxW-1:0]   idx_q, idx_d;
    logic [LevelW-1:0] tval;
    logic              adv_en;

    assign tval = ({1'b0, idx_q} < (IdxW + 1)'(TABLE_LENGTH))
                ? mclbp_pkg::BreathTable[idx_q] : '0;
    assign level_new[i] = pwm_inc <= tval;

    if (i < EnW) begin : g_en
      assign adv_en = step_fire && s1_enable_q[i];
    end else begin : g_no_en
      assign adv_en = 1'b0;
    end

    always_comb begin
      idx_d = idx_q;
      if (adv_en) begin
        if ({1'b0, idx_q} >= (IdxW + 1)'(TABLE_LENGTH - 1)) begin
          idx_d = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        idx_q <= IdxRst;
      end else if (s1_adv) begin
        idx_q <= idx_d;
      end
    end
  end

  // Levels hold on a wrapping tick.
  logic [CHANNELS-1:0] level_bits_d;
  assign level_bits_d = wrap ? level_bits_q : level_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_bits_q <= '0;
    end else if (s1_adv) begin
      level_bits_q <= level_bits_d;
    end
  end

  // Map channel levels onto the 16-bit result field.
  logic [15:0] led_levels_d;
  for (genvar b = 0; b < 16; b++) begin : g_map
    if (b < CHANNELS) begin : g_on
      assign led_levels_d[b] = level_bits_d[b];
    end else begin : g_off
      assign led_levels_d[b] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      led_levels_o      <= led_levels_d;
      counter_wrapped_o <= wrap;
    end
  end

endmodule

`default_nettype wire
